>>> rtl/kbpt_pkg.sv
// ----------------------------------------------------------------------------
// kbpt_pkg
// Shared types and constants for the keyed blocked process table.
// ----------------------------------------------------------------------------
`default_nettype none

package kbpt_pkg;

	localparam int CELLS_DEF       = 16;
	localparam int DESCRIPTORS_DEF = 16;
	localparam int KEY_W           = 32;
	localparam int PID_W           = 4;
	localparam int PRIO_W          = 32;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} kbpt_op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOFREE  = 2'd1,
		ST_NOKEY   = 2'd2,
		ST_BLOCKED = 2'd3
	} kbpt_status_t;

	typedef enum logic {
		S_IDLE  = 1'b0,
		S_APPLY = 1'b1
	} kbpt_state_t;

	// one queue entry as held by a cell
	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  key;
		logic [PID_W-1:0]  pid;
		logic [PRIO_W-1:0] prio;
	} kbpt_entry_t;

	// broadcast from the control to every cell
	typedef struct packed {
		logic              cap;     // input word taken: latch compare flags
		logic              op_ins;  // word in flight is an insert
		logic              ins;     // commit insert
		logic              rem;     // commit remove
		logic [KEY_W-1:0]  cmp_key; // compare operands (input ports)
		logic [PID_W-1:0]  cmp_pid;
		logic [PRIO_W-1:0] cmp_prio;
		logic [KEY_W-1:0]  new_key; // entry written on insert
		logic [PID_W-1:0]  new_pid;
		logic [PRIO_W-1:0] new_prio;
	} kbpt_cmd_t;

	// prefix bits rippling from cell 0 upward
	typedef struct packed {
		logic after;  // at or past the insert/remove position
		logic seen;   // a cell of this key was seen
	} kbpt_chain_t;

	// per-cell status toward the reductions
	typedef struct packed {
		logic key_hit;
		logic pid_hit;
		logic twice;  // key match with an earlier key match
		logic first;  // first hit (queue head on remove)
	} kbpt_flags_t;

endpackage

`default_nettype wire

>>> rtl/kbpt_cell.sv
// ----------------------------------------------------------------------------
// kbpt_cell
// One slot of the packed wait queue: compares against the incoming word,
// joins the position chain and shifts up or down with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module kbpt_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  kbpt_pkg::kbpt_cmd_t   cmd,
	input  kbpt_pkg::kbpt_entry_t left,
	input  kbpt_pkg::kbpt_entry_t right,
	input  kbpt_pkg::kbpt_chain_t chain_in,
	output kbpt_pkg::kbpt_chain_t chain_out,
	output kbpt_pkg::kbpt_entry_t entry,
	output kbpt_pkg::kbpt_flags_t flags
);
	import kbpt_pkg::*;

	logic              valid_q;
	logic [KEY_W-1:0]  key_q;
	logic [PID_W-1:0]  pid_q;
	logic [PRIO_W-1:0] prio_q;
	logic              key_eq_s1;
	logic              pid_eq_s1;
	logic              ge_s1;
	logic              key_hit;
	logic              hit;
	logic              is_pos;

	// compare flags, taken with the input word
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			key_eq_s1 <= (cmd.cmp_key == key_q);
			pid_eq_s1 <= (cmd.cmp_pid == pid_q);
			ge_s1     <= ($signed(cmd.cmp_prio) >= $signed(prio_q));
		end
	end

	// position chain
	always_comb begin
		key_hit         = valid_q & key_eq_s1;
		hit             = key_hit & (cmd.op_ins ? ge_s1 : 1'b1);
		chain_out.after = chain_in.after | hit | (cmd.op_ins & ~valid_q);
		chain_out.seen  = chain_in.seen | key_hit;
		is_pos          = chain_out.after & ~chain_in.after;
		flags.key_hit   = key_hit;
		flags.pid_hit   = valid_q & pid_eq_s1;
		flags.twice     = key_hit & chain_in.seen;
		flags.first     = hit & ~chain_in.after;
	end

	// occupancy: insert grows the packed run by one, remove pulls down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.ins) begin
			valid_q <= valid_q | left.valid;
		end else if (cmd.rem && chain_out.after) begin
			valid_q <= right.valid;
		end
	end

	// payload shift
	always_ff @(posedge clk) begin
		if (cmd.ins && is_pos) begin
			key_q  <= cmd.new_key;
			pid_q  <= cmd.new_pid;
			prio_q <= cmd.new_prio;
		end else if (cmd.ins && chain_in.after) begin
			key_q  <= left.key;
			pid_q  <= left.pid;
			prio_q <= left.prio;
		end else if (cmd.rem && chain_out.after) begin
			key_q  <= right.key;
			pid_q  <= right.pid;
			prio_q <= right.prio;
		end
	end

	assign entry.valid = valid_q;
	assign entry.key   = key_q;
	assign entry.pid   = pid_q;
	assign entry.prio  = prio_q;

endmodule

`default_nettype wire

>>> rtl/keyed_blocked_process_table.sv
// An accepted word latches the compare flags in every cell and moves the
// control to the apply state, where the cell row shifts and the result is
// registered. Input is taken only in idle, and not while a result stalls.
// Reset: arst_n clears all cell valid bits, the key count and the control;
// the table is ready as soon as reset is released.
// ----------------------------------------------------------------------------
// keyed_blocked_process_table
// Priority-ordered wait queues per semaphore key, held in one packed row
// of cells. Insert shifts later cells up, remove shifts them down.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_blocked_process_table #(
	parameter int CELLS       = kbpt_pkg::CELLS_DEF,
	parameter int DESCRIPTORS = kbpt_pkg::DESCRIPTORS_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  wire                        op,
	input  wire  [kbpt_pkg::KEY_W-1:0]  sem_key,
	input  wire  [kbpt_pkg::PID_W-1:0]  proc_id,
	input  wire  [kbpt_pkg::PRIO_W-1:0] proc_priority,
	output logic                       out_valid,
	input  wire                        out_ready,
	output logic [kbpt_pkg::PID_W-1:0]  removed_id,
	output logic [1:0]                 status
);
	import kbpt_pkg::*;

	localparam int KW = $clog2(DESCRIPTORS + 1);

	kbpt_state_t       state_q, state_d;
	logic              op_q;
	logic [KEY_W-1:0]  key_q;
	logic [PID_W-1:0]  pid_q;
	logic [PRIO_W-1:0] prio_q;
	logic [KW-1:0]     kiu_q;
	logic              out_valid_q;
	logic [PID_W-1:0]  removed_id_q;
	kbpt_status_t      status_q;

	kbpt_cmd_t         cmd;
	kbpt_entry_t       ent   [CELLS];
	kbpt_flags_t       flg   [CELLS];
	kbpt_chain_t       chain [CELLS+1];

	logic              accept;
	logic              apply;
	logic              is_ins;
	logic              blocked;
	logic              known;
	logic              twice;
	logic              full;
	logic              nofree;
	logic              do_ins;
	logic              do_rem;
	logic [PID_W-1:0]  head_pid;
	kbpt_status_t      status_d;

	assign accept = in_valid && in_ready;
	assign apply  = (state_q == S_APPLY);
	assign is_ins = (op_q == OP_INSERT);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = !out_valid_q || out_ready;
				if (in_valid && in_ready) begin
					state_d = S_APPLY;
				end
			end
			S_APPLY: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// input word held for the shift cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op;
			key_q  <= sem_key;
			pid_q  <= proc_id;
			prio_q <= proc_priority;
		end
	end

	// reductions over the cell row
	always_comb begin
		blocked  = 1'b0;
		known    = 1'b0;
		twice    = 1'b0;
		head_pid = '0;
		for (int i = 0; i < CELLS; i++) begin
			blocked  = blocked | flg[i].pid_hit;
			known    = known | flg[i].key_hit;
			twice    = twice | flg[i].twice;
			head_pid = head_pid | ({PID_W{flg[i].first}} & ent[i].pid);
		end
	end

	// decision
	always_comb begin
		full   = ent[CELLS-1].valid;
		nofree = (!known && (kiu_q >= KW'(DESCRIPTORS))) || full;
		do_ins = apply && is_ins && !blocked && !nofree;
		do_rem = apply && !is_ins && known;
		priority if (is_ins && blocked) begin
			status_d = ST_BLOCKED;
		end else if (is_ins && nofree) begin
			status_d = ST_NOFREE;
		end else if (!is_ins && !known) begin
			status_d = ST_NOKEY;
		end else begin
			status_d = ST_OK;
		end
	end

	// broadcast to the cells
	always_comb begin
		cmd.cap      = accept;
		cmd.op_ins   = is_ins;
		cmd.ins      = do_ins;
		cmd.rem      = do_rem;
		cmd.cmp_key  = sem_key;
		cmd.cmp_pid  = proc_id;
		cmd.cmp_prio = proc_priority;
		cmd.new_key  = key_q;
		cmd.new_pid  = pid_q;
		cmd.new_prio = prio_q;
	end

	assign chain[0] = '0;

	// cell row
	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		kbpt_entry_t left_e;
		kbpt_entry_t right_e;

		if (i == 0) begin : g_first
			always_comb begin
				left_e       = '0;
				left_e.valid = 1'b1;
			end
		end else begin : g_mid
			assign left_e = ent[i-1];
		end

		if (i == CELLS - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_inner
			assign right_e = ent[i+1];
		end

		kbpt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.left      (left_e),
			.right     (right_e),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1]),
			.entry     (ent[i]),
			.flags     (flg[i])
		);
	end

	// descriptor count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kiu_q <= '0;
		end else if (do_ins && !known) begin
			kiu_q <= kiu_q + KW'(1);
		end else if (do_rem && !twice && (kiu_q != '0)) begin
			kiu_q <= kiu_q - KW'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (apply) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply) begin
			status_q     <= status_d;
			removed_id_q <= do_rem ? head_pid : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign removed_id = removed_id_q;
	assign status     = status_q;

endmodule

`default_nettype wire

>>> rtl/kbpt_checker.sv
// ----------------------------------------------------------------------------
// kbpt_checker
// Port-level checks of the blocked process table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kbpt_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        in_valid,
	input wire                        in_ready,
	input wire                        op,
	input wire [kbpt_pkg::KEY_W-1:0]  sem_key,
	input wire [kbpt_pkg::PID_W-1:0]  proc_id,
	input wire [kbpt_pkg::PRIO_W-1:0] proc_priority,
	input wire                        out_valid,
	input wire                        out_ready,
	input wire [kbpt_pkg::PID_W-1:0]  removed_id,
	input wire [1:0]                  status
);
	import kbpt_pkg::*;

	// every accepted word yields a result once the apply state has registered it
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 out_valid)
		else $error("no result after accepted word");

	// one word in flight: no accept in the cycle after an accept
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word accepted during shift cycle");

	// a stalled result blocks new input
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result stalled");

	// failed operations report no process
	a_fail_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (removed_id == '0))
		else $error("removed id set on failed operation");

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(removed_id))
		else $error("result changed while stalled");

endmodule

bind keyed_blocked_process_table kbpt_checker u_kbpt_checker (.*);

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks keyed_blocked_process_table against a behavioral copy of the wait
// queues. Each word taken at the input updates the copy, and the copy's
// answer is queued. Every result word is compared with the oldest answer.
// A short directed run covers the queue ordering, blocked ids, an unknown
// key and a full table. Three random phases follow, each with its own
// sender and receiver idle rates.
// ----------------------------------------------------------------------------

module testbench;

	import kbpt_pkg::*;

	localparam int CELLS       = CELLS_DEF;
	localparam int DESCRIPTORS = DESCRIPTORS_DEF;
	localparam int KEY_POOL    = 5;
	localparam int PHASE_WORDS = 475;

	typedef struct packed {
		kbpt_op_t          op;
		logic [KEY_W-1:0]  key;
		logic [PID_W-1:0]  pid;
		logic [PRIO_W-1:0] prio;
	} word_t;

	typedef struct packed {
		logic [PID_W-1:0] id;
		kbpt_status_t     st;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_ready = 1'b0;
	word_t drive_word = '0;
	logic in_ready;
	logic out_valid;
	logic [PID_W-1:0] removed_id;
	logic [1:0] status;

	word_t   pending_words[$];
	result_t expected_results[$];
	logic    word_taken = 1'b0;
	int      error_count = 0;
	int      send_idle_pct = 0;
	int      recv_idle_pct = 0;

	// copy of the cell row, packed from index 0
	logic [KEY_W-1:0]         tab_key[CELLS];
	logic [PID_W-1:0]         tab_pid[CELLS];
	logic signed [PRIO_W-1:0] tab_prio[CELLS];
	int                       cells_used = 0;
	int                       keys_held = 0;
	logic [KEY_W-1:0]         key_pool[KEY_POOL];

	keyed_blocked_process_table u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (drive_word.op),
		.sem_key      (drive_word.key),
		.proc_id      (drive_word.pid),
		.proc_priority(drive_word.prio),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.removed_id   (removed_id),
		.status       (status)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// apply one word to the queue copy and return the answer it earns
	function automatic result_t wait_table_apply(word_t w);
		result_t r;
		logic    known;
		logic    placed;
		int      pos;
		int      i;
		r.id = '0;
		r.st = ST_OK;
		known = 1'b0;
		placed = 1'b0;
		pos = cells_used;
		if (w.op == OP_INSERT) begin
			for (i = 0; i < cells_used; i++) begin
				if (tab_pid[i] == w.pid)
					r.st = ST_BLOCKED;
				if (tab_key[i] == w.key)
					known = 1'b1;
			end
			if (r.st == ST_OK && ((!known && keys_held >= DESCRIPTORS) || cells_used >= CELLS))
				r.st = ST_NOFREE;
			if (r.st == ST_OK) begin
				// ahead of the first same-key entry whose priority is not higher
				for (i = 0; i < cells_used; i++) begin
					if (!placed && tab_key[i] == w.key && $signed(w.prio) >= tab_prio[i]) begin
						pos = i;
						placed = 1'b1;
					end
				end
				for (i = cells_used; i > pos; i--) begin
					tab_key[i] = tab_key[i-1];
					tab_pid[i] = tab_pid[i-1];
					tab_prio[i] = tab_prio[i-1];
				end
				tab_key[pos] = w.key;
				tab_pid[pos] = w.pid;
				tab_prio[pos] = $signed(w.prio);
				cells_used++;
				if (!known)
					keys_held++;
			end
		end else begin
			// head of the queue is the first cell of the key
			for (i = 0; i < cells_used; i++) begin
				if (!placed && tab_key[i] == w.key) begin
					pos = i;
					placed = 1'b1;
				end
			end
			if (!placed) begin
				r.st = ST_NOKEY;
			end else begin
				r.id = tab_pid[pos];
				for (i = pos; i < cells_used - 1; i++) begin
					tab_key[i] = tab_key[i+1];
					tab_pid[i] = tab_pid[i+1];
					tab_prio[i] = tab_prio[i+1];
				end
				cells_used--;
				for (i = 0; i < cells_used; i++)
					if (tab_key[i] == w.key)
						known = 1'b1;
				if (!known)
					keys_held--;
			end
		end
		return r;
	endfunction

	function automatic void push_word(kbpt_op_t op, logic [KEY_W-1:0] key,
		logic [PID_W-1:0] pid, logic [PRIO_W-1:0] prio);
		word_t w;
		w.op = op;
		w.key = key;
		w.pid = pid;
		w.prio = prio;
		pending_words.push_back(w);
	endfunction

	// keys mostly from a small pool so queues grow; priorities often tie
	function automatic word_t random_word(int insert_pct);
		word_t w;
		int    sel;
		w.op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
		w.key = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(KEY_POOL-1)];
		w.pid = PID_W'($urandom_range(15));
		sel = $urandom_range(9);
		case (sel)
			0: w.prio = 32'h8000_0000;
			1: w.prio = 32'h7fff_ffff;
			2: w.prio = 32'hffff_ffff;
			3, 4, 5: w.prio = $urandom_range(6) - 3;
			default: w.prio = $urandom();
		endcase
		return w;
	endfunction

	// driver: payload and ready change on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
			if (!in_valid || word_taken) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drive_word <= pending_words.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check result words, then predict for the word taken
	always @(posedge clk) begin : monitor
		result_t due;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result word with none expected: removed_id %0d status %0d",
						removed_id, status);
					error_count++;
				end else begin
					due = expected_results.pop_front();
					if (removed_id !== due.id) begin
						$error("removed_id expected %0d actual %0d", due.id, removed_id);
						error_count++;
					end
					if (status !== due.st) begin
						$error("status expected %0d actual %0d", due.st, status);
						error_count++;
					end
				end
			end
			if (in_valid && in_ready)
				expected_results.push_back(wait_table_apply(drive_word));
		end
		word_taken <= in_valid && in_ready;
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : stimulus
		int phase;
		int n;
		int insert_pct;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// directed: ordering, ties, blocked id, unknown key, full table
		send_idle_pct = 6;
		recv_idle_pct = 76;
		push_word(OP_REMOVE, 32'h0, PID_W'($urandom_range(15)), $urandom());
		push_word(OP_INSERT, 32'h0, 4'd0, 32'h7fff_ffff);
		push_word(OP_INSERT, 32'h0, 4'd1, 32'h8000_0000);
		push_word(OP_INSERT, 32'h0, 4'd2, 32'h7fff_ffff);
		push_word(OP_INSERT, 32'hffff_ffff, 4'd0, 32'h0);
		push_word(OP_INSERT, 32'hffff_ffff, 4'd3, 32'h0);
		push_word(OP_INSERT, 32'hffff_ffff, 4'd4, 32'hffff_ffff);
		push_word(OP_REMOVE, 32'h0, PID_W'($urandom_range(15)), $urandom());
		push_word(OP_REMOVE, 32'h0, PID_W'($urandom_range(15)), $urandom());
		push_word(OP_REMOVE, 32'h0, PID_W'($urandom_range(15)), $urandom());
		push_word(OP_REMOVE, 32'h0, PID_W'($urandom_range(15)), $urandom());
		// fill all cells with one key each for the remaining ids
		for (n = 0; n < 14; n++)
			push_word(OP_INSERT, KEY_W'(n + 1), PID_W'((n < 3) ? n : n + 2), $urandom());
		push_word(OP_INSERT, 32'h1234_5678, 4'd7, 32'h7fff_ffff);

		// random phases; each starts only after the previous one drained
		for (phase = 0; phase < 3; phase++) begin
			while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
				@(negedge clk);
			send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 76 : 0;
			recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 6 : 0;
			key_pool[0] = 32'h0;
			key_pool[1] = 32'hffff_ffff;
			for (n = 2; n < KEY_POOL; n++)
				key_pool[n] = $urandom();
			insert_pct = 70;
			for (n = 0; n < PHASE_WORDS; n++) begin
				// swing between filling and draining the table
				if (n % 40 == 0)
					insert_pct = (insert_pct == 70) ? 35 : 70;
				pending_words.push_back(random_word(insert_pct));
			end
		end

		while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> keyed_blocked_process_table.f
rtl/kbpt_pkg.sv
rtl/kbpt_cell.sv
rtl/keyed_blocked_process_table.sv
rtl/kbpt_checker.sv
tb/sv/testbench.sv
